### hdl/petrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package petrc_pkg;

   localparam int TABLE_ENTRIES_DEF = 1024;
   localparam int REASON_COUNT_DEF  = 128;
   localparam int TID_SLOTS_DEF     = 4;

   localparam int SLOT_REGS = 4;
   localparam int ID_W      = 23;
   localparam int REASON_W  = 8;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_PID = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_TID = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TID_SLOT_0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TID_SLOT_1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TID_SLOT_2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TID_SLOT_3 = 3'd5;

   typedef enum logic [STATUS_W-1:0] {
      ST_COUNTED    = 2'd0,
      ST_BAD_REASON = 2'd1,
      ST_FILTERED   = 2'd2,
      ST_FULL       = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FILTER,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_CNT_RD,
      S_CNT_WR,
      S_RESULT
   } state_type;

endpackage

`default_nettype wire

### hdl/petrc_filter.sv
`timescale 1ns / 1ps
`default_nettype none

module petrc_filter #(
   parameter int TID_SLOTS = petrc_pkg::TID_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [petrc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [petrc_pkg::ID_W-1:0]      csr_wdata,
   input  logic [petrc_pkg::ID_W-1:0]      pid,
   input  logic [petrc_pkg::ID_W-1:0]      tid,
   output logic                           pass
);
   import petrc_pkg::*;

   localparam int SEL_W = $clog2(SLOT_REGS);

   logic [ID_W-1:0]                 filter_pid_ff;
   logic [ID_W-1:0]                 filter_tid_ff;
   logic [SLOT_REGS-1:0][ID_W-1:0] slot_ff;
   logic [SEL_W-1:0]                slot_sel;
   logic                            list_ok;
   logic                            live;

   assign slot_sel = SEL_W'(csr_index - CSR_TID_SLOT_0);

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_pid_ff <= '0;
         filter_tid_ff <= '0;
         slot_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index) inside
            CSR_FILTER_PID: filter_pid_ff <= csr_wdata;
            CSR_FILTER_TID: filter_tid_ff <= csr_wdata;
            CSR_TID_SLOT_0, CSR_TID_SLOT_1, CSR_TID_SLOT_2, CSR_TID_SLOT_3:
               slot_ff[slot_sel] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // list ends at its first empty slot
   always_comb begin
      list_ok = 1'b0;
      live    = 1'b1;
      for (int i = 0; i < TID_SLOTS; i++) begin
         if (slot_ff[i] == '0) begin
            live = 1'b0;
         end else if (live && (slot_ff[i] == tid)) begin
            list_ok = 1'b1;
         end
      end
      if (slot_ff[0] == '0) begin
         list_ok = 1'b1;
      end
      pass = ((filter_pid_ff == '0) || (filter_pid_ff == pid)) &&
             ((filter_tid_ff == '0) || (filter_tid_ff == tid)) && list_ok;
   end

endmodule

`default_nettype wire

### hdl/per_thread_event_reason_counter.sv
// Per-thread event reason counter.
// Request channel (req_valid / req_stall) carries one event beat: process id,
// thread id and reason code. Response channel (rsp_valid / rsp_stall) returns
// one beat per event: status and the updated 64-bit count (zero unless the
// status is counted). The csr_ port writes the pid / tid filters and the
// allowed-thread list; write it only while the block is idle.
// Keys live in a hashed table with linear probing; counters live in a second
// memory addressed by table slot and reason.
// Throughput: one event at a time. An event found or inserted on its first
// probe steps through filter, probe read, probe check, counter read, counter
// write and result; each further probe adds a probe read and check (memory
// read plus compare). Rejected events go from filter to result. The response
// lands in an output register; the block accepts again while it waits there.
// Reset: a clearing pass walks all 2**ceil(log2(TABLE_ENTRIES)) key-table
// entries (1024 at default) with req_stall high; csr writes are taken as ever.
// A stalled response holds; the block finishes the next event and waits for
// the output register to free before loading it.
`timescale 1ns / 1ps
`default_nettype none

module per_thread_event_reason_counter #(
   parameter int TABLE_ENTRIES = petrc_pkg::TABLE_ENTRIES_DEF,
   parameter int REASON_COUNT  = petrc_pkg::REASON_COUNT_DEF,
   parameter int TID_SLOTS     = petrc_pkg::TID_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [petrc_pkg::ID_W-1:0]      req_proc_id,
   input  logic [petrc_pkg::ID_W-1:0]      req_thread_id,
   input  logic [petrc_pkg::REASON_W-1:0]  req_reason_code,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [petrc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [petrc_pkg::COUNT_W-1:0]   rsp_new_count,
   input  logic                            csr_we,
   input  logic [petrc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [petrc_pkg::ID_W-1:0]      csr_wdata
);
   import petrc_pkg::*;

   localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int DEPTH     = 2 ** IDX_W;
   localparam int RSN_W     = (REASON_COUNT > 1) ? $clog2(REASON_COUNT) : 1;
   localparam int CNT_DEPTH = DEPTH * (2 ** RSN_W);
   localparam int FILL_W    = $clog2(TABLE_ENTRIES + 1);

   typedef struct packed {
      logic                    valid;
      logic [ID_W-1:0]         pid;
      logic [ID_W-1:0]         tid;
      logic [REASON_COUNT-1:0] touched;
   } row_type;

   row_type              slot_mem [DEPTH];
   logic [COUNT_W-1:0]   cnt_mem  [CNT_DEPTH];

   state_type            state_ff, state_in;
   logic [ID_W-1:0]      pid_ff;
   logic [ID_W-1:0]      tid_ff;
   logic [REASON_W-1:0]  reason_ff;
   logic [IDX_W-1:0]     probe_idx_ff;
   logic [IDX_W-1:0]     probe_cnt_ff;
   logic [IDX_W-1:0]     clr_idx_ff;
   logic [FILL_W-1:0]    fill_ff;
   row_type              row_ff;
   row_type              slot_rd_ff;
   logic [COUNT_W-1:0]   cnt_rd_ff;
   status_type           status_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 pass;
   logic                 bad_reason;
   logic                 hit;
   logic                 table_full;
   logic                 out_free;
   logic [RSN_W-1:0]     rsn_idx;
   logic [IDX_W+RSN_W-1:0] cnt_addr;
   logic [COUNT_W-1:0]   cnt_new;
   row_type              row_upd;
   logic                 slot_we;
   logic [IDX_W-1:0]     slot_waddr;
   row_type              slot_wdata;
   logic                 cnt_we;
   logic                 load_rsp;

   function automatic logic [IDX_W-1:0] hash_key(input logic [ID_W-1:0] p,
                                                   input logic [ID_W-1:0] t);
      logic [2*ID_W-1:0] k;
      logic [IDX_W-1:0]  h;
      k = {p, t};
      h = '0;
      for (int i = 0; i < 2 * ID_W; i++) begin
         h[i % IDX_W] = h[i % IDX_W] ^ k[i];
      end
      return h;
   endfunction

   petrc_filter #(
      .TID_SLOTS (TID_SLOTS)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pid       (pid_ff),
      .tid       (tid_ff),
      .pass      (pass)
   );

   assign bad_reason = {1'b0, reason_ff} >= (REASON_W + 1)'(REASON_COUNT);
   assign hit        = slot_rd_ff.valid && (slot_rd_ff.pid == pid_ff) &&
                       (slot_rd_ff.tid == tid_ff);
   assign table_full = fill_ff == FILL_W'(TABLE_ENTRIES);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsn_idx    = reason_ff[RSN_W-1:0];
   assign cnt_addr   = {probe_idx_ff, rsn_idx};
   assign cnt_new    = (row_ff.touched[rsn_idx] ? cnt_rd_ff : '0) + COUNT_W'(1);

   always_comb begin
      row_upd                  = row_ff;
      row_upd.touched[rsn_idx] = 1'b1;
   end

   // key table
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[probe_idx_ff];
   end

   // counter memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_addr] <= cnt_new;
      end
      cnt_rd_ff <= cnt_mem[cnt_addr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_idx_ff == IDX_W'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_FILTER;
         end
         S_FILTER: begin
            if (bad_reason || !pass) state_in = S_RESULT;
            else state_in = S_PROBE_RD;
         end
         S_PROBE_RD: state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            if (hit) begin
               state_in = S_CNT_RD;
            end else if (!slot_rd_ff.valid) begin
               state_in = table_full ? S_RESULT : S_CNT_RD;
            end else if (probe_cnt_ff == IDX_W'(DEPTH - 1)) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_PROBE_RD;
            end
         end
         S_CNT_RD: state_in = S_CNT_WR;
         S_CNT_WR: state_in = S_RESULT;
         S_RESULT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      slot_we    = 1'b0;
      slot_waddr = probe_idx_ff;
      slot_wdata = row_upd;
      cnt_we     = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_idx_ff;
            slot_wdata = '0;
         end
         S_IDLE: req_stall = 1'b0;
         S_CNT_WR: begin
            slot_we = 1'b1;
            cnt_we  = 1'b1;
         end
         S_RESULT: load_rsp = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + IDX_W'(1);
         end
         if ((state_ff == S_PROBE_CHK) && !slot_rd_ff.valid && !table_full) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            pid_ff    <= req_proc_id;
            tid_ff    <= req_thread_id;
            reason_ff <= req_reason_code;
         end
         S_FILTER: begin
            probe_idx_ff <= hash_key(pid_ff, tid_ff);
            probe_cnt_ff <= '0;
            status_ff    <= bad_reason ? ST_BAD_REASON : ST_FILTERED;
         end
         S_PROBE_CHK: begin
            if (hit) begin
               row_ff <= slot_rd_ff;
            end else if (!slot_rd_ff.valid) begin
               row_ff    <= '{valid: 1'b1, pid: pid_ff, tid: tid_ff, touched: '0};
               status_ff <= ST_FULL;
            end else begin
               probe_idx_ff <= probe_idx_ff + IDX_W'(1);
               probe_cnt_ff <= probe_cnt_ff + IDX_W'(1);
               status_ff    <= ST_FULL;
            end
         end
         S_CNT_WR: begin
            count_ff  <= cnt_new;
            status_ff <= ST_COUNTED;
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_status_ff <= status_ff;
               rsp_count_ff  <= (status_ff == ST_COUNTED) ? count_ff : '0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_new_count = rsp_count_ff;

endmodule

`default_nettype wire

### hdl/petrc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module petrc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [petrc_pkg::STATUS_W-1:0] rsp_status,
   input logic [petrc_pkg::COUNT_W-1:0]  rsp_new_count
);
   import petrc_pkg::*;

   // reset empties the output and starts the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("response or ready right after reset");

   // one event at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous event in flight");

   a_count_zero_unless_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_COUNTED)) |-> (rsp_new_count == '0))
      else $error("nonzero count on rejected event");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_new_count)))
      else $error("stalled response beat changed");

endmodule

bind per_thread_event_reason_counter petrc_checker u_petrc_checker (.*);

`default_nettype wire

### sim/tb_per_thread_event_reason_counter.sv
`timescale 1ns / 1ps

module tb_per_thread_event_reason_counter;
   import petrc_pkg::*;

   localparam int PERIOD = 20;
   localparam int ENTRIES = TABLE_ENTRIES_DEF;
   localparam int REASONS = REASON_COUNT_DEF;
   localparam int LIST_LEN = TID_SLOTS_DEF;
   localparam int ID_TOP = (1 << ID_W) - 1;
   localparam int POOL = 12;
   localparam int HOLD_CYCLES = 400;
   localparam longint LIMIT_CYCLES = 10_000_000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 3'd7;

   typedef bit [ID_W-1:0] id_type;
   typedef bit [REASON_W-1:0] reason_type;

   typedef struct {
      status_type status;
      bit [COUNT_W-1:0] count;
   } tally_beat_type;

   class reason_tally;
      id_type want_pid;
      id_type want_tid;
      id_type allowed[SLOT_REGS];
      bit [COUNT_W-1:0] counter[bit [2*ID_W+REASON_W-1:0]];
      bit key_known[bit [2*ID_W-1:0]];
      int keys_taken;
      tally_beat_type pending[$];
      int errors;
      int beats_checked;
      int by_status[4];

      function void set_reg(logic [CSR_IDX_W-1:0] idx, id_type v);
         case (idx)
            CSR_FILTER_PID: want_pid = v;
            CSR_FILTER_TID: want_tid = v;
            CSR_TID_SLOT_0: allowed[0] = v;
            CSR_TID_SLOT_1: allowed[1] = v;
            CSR_TID_SLOT_2: allowed[2] = v;
            CSR_TID_SLOT_3: allowed[3] = v;
            default: ;
         endcase
      endfunction

      function bit admits(id_type pid, id_type tid);
         if (want_pid != 0 && want_pid != pid) return 1'b0;
         if (want_tid != 0 && want_tid != tid) return 1'b0;
         if (allowed[0] == 0) return 1'b1;
         for (int i = 0; i < LIST_LEN && i < SLOT_REGS; i++) begin
            if (allowed[i] == 0) return 1'b0;
            if (allowed[i] == tid) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_event(id_type pid, id_type tid, reason_type reason);
         tally_beat_type b;
         bit [2*ID_W-1:0] key;
         bit [2*ID_W+REASON_W-1:0] slot;
         key = {pid, tid};
         slot = {pid, tid, reason};
         b.count = '0;
         if (reason >= REASONS) begin
            b.status = ST_BAD_REASON;
         end else if (!admits(pid, tid)) begin
            b.status = ST_FILTERED;
         end else if (!key_known.exists(key) && keys_taken == ENTRIES) begin
            b.status = ST_FULL;
         end else begin
            if (!key_known.exists(key)) begin
               key_known[key] = 1'b1;
               keys_taken++;
            end
            if (!counter.exists(slot)) counter[slot] = '0;
            counter[slot] = counter[slot] + 1'b1;
            b.status = ST_COUNTED;
            b.count = counter[slot];
         end
         pending.push_back(b);
      endfunction

      task report(string what);
         $display("%0t ns  mismatch: %s", $time, what);
         errors++;
      endtask

      task check_beat(status_type status, logic [COUNT_W-1:0] count);
         tally_beat_type b;
         if (pending.size() == 0) begin
            report($sformatf("unexpected beat, status %0d count %0d", status, count));
            return;
         end
         b = pending.pop_front();
         beats_checked++;
         by_status[b.status]++;
         if (status !== b.status)
            report($sformatf("beat %0d status %0d, expected %0d",
                             beats_checked, status, b.status));
         if (count !== b.count)
            report($sformatf("beat %0d count %0d, expected %0d",
                             beats_checked, count, b.count));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ID_W-1:0] req_proc_id = '0;
   logic [ID_W-1:0] req_thread_id = '0;
   logic [REASON_W-1:0] req_reason_code = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0] rsp_new_count;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ID_W-1:0] csr_wdata = '0;

   reason_tally tally = new();

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int events_sent = 0;
   id_type known_pid[$];
   id_type known_tid[$];

   per_thread_event_reason_counter u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_proc_id     (req_proc_id),
      .req_thread_id   (req_thread_id),
      .req_reason_code (req_reason_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_new_count   (rsp_new_count),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   // receiver: random stalls plus a single long hold-off
   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tally.check_beat(status_type'(rsp_status), rsp_new_count);
   end

   function automatic id_type nonzero_id();
      return id_type'($urandom_range(ID_TOP, 1));
   endfunction

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 71; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 71; end
         default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
   endtask

   task automatic send_event(id_type pid, id_type tid, reason_type reason);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_proc_id <= pid;
      req_thread_id <= tid;
      req_reason_code <= reason;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tally.note_event(pid, tid, reason);
      events_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tally.pending.size() != 0) @(negedge clock);
   endtask

   task automatic program_filters(id_type pid, id_type tid, id_type s0, id_type s1,
                                  id_type s2, id_type s3);
      logic [CSR_IDX_W-1:0] regs[8];
      id_type vals[8];
      regs = '{CSR_UNUSED_A, CSR_FILTER_PID, CSR_FILTER_TID, CSR_TID_SLOT_0,
               CSR_TID_SLOT_1, CSR_TID_SLOT_2, CSR_TID_SLOT_3, CSR_UNUSED_B};
      vals = '{id_type'($urandom), pid, tid, s0, s1, s2, s3, id_type'($urandom)};
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(negedge clock);
         tally.set_reg(regs[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(int n_items, bit with_hold);
      id_type pool_pid[POOL];
      id_type pool_tid[POOL];
      id_type tid_hint[$];
      id_type pid;
      id_type tid;
      reason_type reason;
      int pick;
      int k;
      if (tally.want_tid != 0) tid_hint.push_back(tally.want_tid);
      for (int i = 0; i < SLOT_REGS; i++)
         if (tally.allowed[i] != 0) tid_hint.push_back(tally.allowed[i]);
      for (int i = 0; i < POOL; i++) begin
         pool_pid[i] = (tally.want_pid != 0 && $urandom_range(3) != 0) ?
                       tally.want_pid : id_type'($urandom);
         pool_tid[i] = (tid_hint.size() != 0 && $urandom_range(3) != 0) ?
                       tid_hint[$urandom_range(tid_hint.size() - 1)] : id_type'($urandom);
      end
      for (int n = 0; n < n_items; n++) begin
         if (with_hold && n == 40) hold_asks++;
         pick = $urandom_range(99);
         k = $urandom_range(POOL - 1);
         pid = pool_pid[k];
         tid = pool_tid[k];
         if (pick < 70) begin
            reason = $urandom_range(1) ? reason_type'($urandom_range(3))
                                       : reason_type'($urandom_range(REASONS - 1));
         end else if (pick < 85) begin
            pid = id_type'($urandom);
            tid = id_type'($urandom);
            reason = reason_type'($urandom_range(REASONS - 1));
         end else begin
            reason = reason_type'($urandom_range(255, REASONS));
         end
         send_event(pid, tid, reason);
      end
   endtask

   task automatic fill_table();
      id_type pid;
      id_type tid;
      int n;
      n = 0;
      while (tally.keys_taken < ENTRIES) begin
         set_idling((n / 200) % 4);
         pid = id_type'($urandom);
         tid = id_type'($urandom);
         if ($urandom_range(9) == 0) begin
            send_event(pid, tid, reason_type'($urandom_range(255, REASONS)));
         end else begin
            send_event(pid, tid, reason_type'($urandom_range(REASONS - 1)));
            known_pid.push_back(pid);
            known_tid.push_back(tid);
            if (known_pid.size() > 64) begin
               void'(known_pid.pop_front());
               void'(known_tid.pop_front());
            end
         end
         n++;
      end
   endtask

   task automatic hit_full_table(int n_items);
      int pick;
      int k;
      for (int n = 0; n < n_items; n++) begin
         set_idling(n % 4);
         pick = $urandom_range(99);
         k = $urandom_range(known_pid.size() - 1);
         if (pick < 45)
            send_event(id_type'($urandom), id_type'($urandom),
                       reason_type'($urandom_range(REASONS - 1)));
         else if (pick < 90)
            send_event(known_pid[k], known_tid[k], reason_type'($urandom_range(3)));
         else
            send_event(known_pid[k], known_tid[k],
                       reason_type'($urandom_range(255, REASONS)));
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      program_filters(0, 0, 0, 0, 0, 0);

      // directed: extremes, repeats, each filter and check order
      send_event(0, 0, 0);
      send_event(0, 0, 0);
      send_event(ID_TOP, ID_TOP, REASONS - 1);
      send_event(0, ID_TOP, REASONS - 1);
      send_event(ID_TOP, 0, 0);
      send_event(1, 1, REASONS);
      send_event(1, 1, 255);
      send_event(1, 1, 5);
      send_event(1, 1, 5);
      send_event(1, 1, 6);
      drain();
      program_filters(ID_TOP, 0, 0, 0, 0, 0);
      send_event(ID_TOP, 3, 1);
      send_event(1, 3, 1);
      send_event(2, 3, 200);
      drain();
      program_filters(0, ID_TOP, 0, 0, 0, 0);
      send_event(5, ID_TOP, 9);
      send_event(5, 4, 9);
      drain();
      // list ends at the first empty slot
      program_filters(0, 0, 5, 9, 0, 11);
      send_event(6, 5, 2);
      send_event(6, 9, 2);
      send_event(6, 11, 2);
      send_event(6, 0, 2);
      drain();
      program_filters(0, 0, 5, 9, 11, ID_TOP);
      send_event(6, ID_TOP, 2);
      send_event(6, 11, 2);
      drain();
      program_filters(3, 9, 5, 0, 0, 0);
      send_event(3, 9, 4);
      send_event(3, 5, 4);

      for (int ph = 0; ph < 4; ph++) begin
         drain();
         case (ph)
            0: program_filters(0, 0, 0, 0, 0, 0);
            1: program_filters(nonzero_id(), 0, 0, nonzero_id(), nonzero_id(), nonzero_id());
            2: program_filters(0, 0, nonzero_id(), nonzero_id(), 0, nonzero_id());
            default: program_filters(ID_TOP, ID_TOP, nonzero_id(), nonzero_id(),
                                     nonzero_id(), ID_TOP);
         endcase
         set_idling(ph);
         random_phase(100, ph == 0);
      end

      drain();
      program_filters(0, 0, 0, 0, 0, 0);
      fill_table();
      hit_full_table(40);

      drain();
      repeat (40) @(negedge clock);
      $display("%0d events checked: %0d counted, %0d bad reason, %0d filtered, %0d table full",
               tally.beats_checked, tally.by_status[ST_COUNTED],
               tally.by_status[ST_BAD_REASON], tally.by_status[ST_FILTERED],
               tally.by_status[ST_FULL]);
      $display("key table taken to %0d of %0d entries under four idling patterns",
               tally.keys_taken, ENTRIES);
      if (tally.errors == 0)
         $display("tb_per_thread_event_reason_counter: clean");
      else
         $display("tb_per_thread_event_reason_counter: errors");
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * PERIOD);
      $display("timeout: %0d events sent, %0d beats outstanding",
               events_sent, tally.pending.size());
      $display("tb_per_thread_event_reason_counter: errors");
      $finish;
   end

endmodule

### sim.f
hdl/petrc_pkg.sv
hdl/petrc_filter.sv
hdl/per_thread_event_reason_counter.sv
hdl/petrc_checker.sv
sim/tb_per_thread_event_reason_counter.sv
